// ----- design/image_header_field_parser_assert.svh -----
// Assertion shorthands shared by the parser RTL.
// Each macro expects clk and rst in scope.
`ifndef IMAGE_HEADER_FIELD_PARSER_ASSERT_SVH
`define IMAGE_HEADER_FIELD_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IHFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ihfp_pkg.sv -----
// ----------------------------------------------------------------------------
// ihfp_pkg
// Shared constants, signature tables and types for the image header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ihfp_pkg;

  localparam int NUM_CAND = 7;

  // result format codes
  localparam logic [2:0] FMT_UNKNOWN = 3'd0;
  localparam logic [2:0] FMT_PNG     = 3'd1;
  localparam logic [2:0] FMT_JPEG    = 3'd2;
  localparam logic [2:0] FMT_GIF     = 3'd3;
  localparam logic [2:0] FMT_BMP     = 3'd4;
  localparam logic [2:0] FMT_TIFF    = 3'd5;
  localparam logic [2:0] FMT_WEBP    = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_UNRECOGNIZED = 2'd1;
  localparam logic [1:0] ST_NO_FRAME     = 2'd2;
  localparam logic [1:0] ST_TRUNCATED    = 2'd3;

  // signature candidate indexes, lowest index wins
  localparam logic [2:0] CAND_PNG  = 3'd0;
  localparam logic [2:0] CAND_JPEG = 3'd1;
  localparam logic [2:0] CAND_GIF  = 3'd2;
  localparam logic [2:0] CAND_BMP  = 3'd3;
  localparam logic [2:0] CAND_TII  = 3'd4;
  localparam logic [2:0] CAND_TMM  = 3'd5;
  localparam logic [2:0] CAND_WEBP = 3'd6;

  localparam logic [5:0] POS_MAX = 6'd63;

  localparam logic [7:0] SOF_FIRST    = 8'hC0;
  localparam logic [7:0] SOF_LAST     = 8'hC3;
  localparam logic [7:0] MARKER_PFX   = 8'hFF;
  localparam logic [7:0] GIF_VER_7    = 8'h37;
  localparam logic [7:0] GIF_VER_9    = 8'h39;
  localparam logic [7:0] WEBP_DEPTH   = 8'd24;

  // signature tables, padded to a power of two
  localparam logic [7:0] SIG_PNG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                         8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [7:0] SIG_JPG [4] = '{8'hFF, 8'hD8, 8'hFF, 8'h00};
  localparam logic [7:0] SIG_GIF [8] = '{8'h47, 8'h49, 8'h46, 8'h38,
                                         8'h37, 8'h61, 8'h00, 8'h00};
  localparam logic [7:0] SIG_BMP [2] = '{8'h42, 8'h4D};
  localparam logic [7:0] SIG_TII [4] = '{8'h49, 8'h49, 8'h2A, 8'h00};
  localparam logic [7:0] SIG_TMM [4] = '{8'h4D, 8'h4D, 8'h00, 8'h2A};
  localparam logic [7:0] SIG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] SIG_WEBP [4] = '{8'h57, 8'h45, 8'h42, 8'h50};

  function automatic logic [3:0] sig_len(input logic [2:0] k);
    case (k)
      CAND_PNG:  sig_len = 4'd8;
      CAND_JPEG: sig_len = 4'd3;
      CAND_GIF:  sig_len = 4'd6;
      CAND_BMP:  sig_len = 4'd2;
      CAND_TII:  sig_len = 4'd4;
      CAND_TMM:  sig_len = 4'd4;
      default:   sig_len = 4'd12;
    endcase
  endfunction

  function automatic logic [2:0] cand_format(input logic [2:0] k);
    case (k)
      CAND_PNG:  cand_format = FMT_PNG;
      CAND_JPEG: cand_format = FMT_JPEG;
      CAND_GIF:  cand_format = FMT_GIF;
      CAND_BMP:  cand_format = FMT_BMP;
      CAND_TII:  cand_format = FMT_TIFF;
      CAND_TMM:  cand_format = FMT_TIFF;
      CAND_WEBP: cand_format = FMT_WEBP;
      default:   cand_format = FMT_UNKNOWN;
    endcase
  endfunction

  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_CODE   = 6'b000010,
    PH_LEN_HI = 6'b000100,
    PH_LEN_LO = 6'b001000,
    PH_SOF    = 6'b010000,
    PH_SKIP   = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] seg_left;
    logic [7:0]  seg_hi;
  } jpeg_state_t;

  typedef struct packed {
    jpeg_state_t st;
    logic        emit;
    logic        frame_ok;
    logic        w_we;
    logic        h_we;
    logic        d_we;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  depth;
    logic [7:0]  depth3;
  } jpeg_step_t;

  typedef struct packed {
    logic [6:0] cand;
    logic       none;
    logic [2:0] first;
  } sig_pick_t;

  typedef struct packed {
    logic [2:0]         fmt;
    logic [1:0]         status;
    logic signed [31:0] width;
    logic signed [31:0] height;
    logic               dims_valid;
    logic [7:0]         bit_depth;
    logic               depth_valid;
    logic [7:0]         color_type;
  } result_t;

endpackage

`default_nettype wire

// ----- design/ihfp_byte_if.sv -----
// ----------------------------------------------------------------------------
// ihfp_byte_if
// Byte stream channel into the parser: one file byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  logic       end_of_file;

  modport source(output valid, data_byte, start_of_file, end_of_file, input ready);
  modport sink(input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

`default_nettype wire

// ----- design/ihfp_result_if.sv -----
// ----------------------------------------------------------------------------
// ihfp_result_if
// Result channel out of the parser: one header summary per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihfp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         format;
  logic [1:0]         status;
  logic signed [31:0] image_width;
  logic signed [31:0] image_height;
  logic               dims_valid;
  logic [7:0]         bit_depth;
  logic               depth_valid;
  logic [7:0]         png_color_type;

  modport source(output valid, format, status, image_width, image_height, dims_valid,
                 bit_depth, depth_valid, png_color_type, input ready);
  modport sink(input valid, format, status, image_width, image_height, dims_valid,
               bit_depth, depth_valid, png_color_type, output ready);
endinterface

`default_nettype wire

// ----- design/ihfp_sig.sv -----
// ----------------------------------------------------------------------------
// ihfp_sig
// Signature matcher: prunes the candidate set by the current byte and picks
// the lowest surviving candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module ihfp_sig import ihfp_pkg::*; (
  input  logic [5:0] pos,
  input  logic [6:0] cand,
  input  logic [7:0] data,
  output sig_pick_t  pick
);

  logic [6:0] match;

  always_comb begin
    match[CAND_PNG]  = (pos >= 6'd8) || (data == SIG_PNG[pos[2:0]]);
    match[CAND_JPEG] = (pos >= 6'd3) || (data == SIG_JPG[pos[1:0]]);
    if (pos >= 6'd6) begin
      match[CAND_GIF] = 1'b1;
    end else if (pos == 6'd4) begin
      match[CAND_GIF] = (data == GIF_VER_7) || (data == GIF_VER_9);
    end else begin
      match[CAND_GIF] = (data == SIG_GIF[pos[2:0]]);
    end
    match[CAND_BMP] = (pos >= 6'd2) || (data == SIG_BMP[pos[0]]);
    match[CAND_TII] = (pos >= 6'd4) || (data == SIG_TII[pos[1:0]]);
    match[CAND_TMM] = (pos >= 6'd4) || (data == SIG_TMM[pos[1:0]]);
    // RIFF, then four size bytes of any value, then WEBP
    if (pos < 6'd4) begin
      match[CAND_WEBP] = (data == SIG_RIFF[pos[1:0]]);
    end else if (pos < 6'd8) begin
      match[CAND_WEBP] = 1'b1;
    end else if (pos < 6'd12) begin
      match[CAND_WEBP] = (data == SIG_WEBP[pos[1:0]]);
    end else begin
      match[CAND_WEBP] = 1'b1;
    end
  end

  always_comb begin
    pick.cand  = cand & match;
    pick.none  = (pick.cand == '0);
    pick.first = CAND_WEBP;
    for (int i = NUM_CAND - 2; i >= 0; i--) begin
      if (pick.cand[i]) begin
        pick.first = 3'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/ihfp_jpeg.sv -----
// ----------------------------------------------------------------------------
// ihfp_jpeg
// One step of the JPEG marker walk: segment skipping and SOF field capture.
// ----------------------------------------------------------------------------
`default_nettype none

module ihfp_jpeg import ihfp_pkg::*; (
  input  jpeg_state_t cur,
  input  logic [7:0]  data,
  input  logic [15:0] width,
  input  logic [15:0] height,
  input  logic [7:0]  depth,
  output jpeg_step_t  step
);

  logic [15:0] seg_len;

  assign seg_len = {cur.seg_hi, data};

  always_comb begin
    step          = '0;
    step.st       = cur;
    step.width    = width;
    step.height   = height;
    step.depth    = depth;
    step.depth3   = {depth[6:0], 1'b0} + depth;
    case (cur.phase)
      PH_PREFIX: begin
        if (data != MARKER_PFX) begin
          step.emit = 1'b1;
        end else begin
          step.st.phase = PH_CODE;
        end
      end
      PH_CODE: begin
        if (data >= SOF_FIRST && data <= SOF_LAST) begin
          step.st.phase    = PH_SOF;
          step.st.seg_left = '0;
        end else begin
          step.st.phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        step.st.seg_hi = data;
        step.st.phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len <= 16'd2) begin
          step.st.seg_left = '0;
          step.st.phase    = PH_PREFIX;
        end else begin
          step.st.seg_left = seg_len - 16'd2;
          step.st.phase    = PH_SKIP;
        end
      end
      PH_SOF: begin
        // frame header: length(2) precision(1) height(2) width(2)
        if (cur.seg_left == 16'd2) begin
          step.d_we  = 1'b1;
          step.depth = data;
        end else if (cur.seg_left == 16'd3 || cur.seg_left == 16'd4) begin
          step.h_we   = 1'b1;
          step.height = {height[7:0], data};
        end else if (cur.seg_left >= 16'd5) begin
          step.w_we  = 1'b1;
          step.width = {width[7:0], data};
        end
        if (cur.seg_left >= 16'd6) begin
          step.emit     = 1'b1;
          step.frame_ok = 1'b1;
        end else begin
          step.st.seg_left = cur.seg_left + 16'd1;
        end
      end
      PH_SKIP: begin
        if (cur.seg_left <= 16'd1) begin
          step.st.seg_left = '0;
          step.st.phase    = PH_PREFIX;
        end else begin
          step.st.seg_left = cur.seg_left - 16'd1;
        end
      end
      default: begin
        step.st.seg_left = '0;
        step.st.phase    = PH_PREFIX;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/image_header_field_parser.sv -----
// ----------------------------------------------------------------------------
// image_header_field_parser
// Streams file bytes, identifies PNG/JPEG/GIF/BMP/TIFF/WEBP and reports
// the image dimensions, bit depth and PNG color type at most once per file.
// ----------------------------------------------------------------------------
//  channel       dir  transaction
//  data_chan     in   one file byte with start/end-of-file flags
//  result_chan   out  one header summary, at most one per file
//
// Each byte is registered, then parsed combinationally into the result
// register; a byte can be taken every cycle while the result side keeps up.
// A stalled result register holds the parser; one byte waits in the input
// register and the input side stalls behind it.
// Reset (synchronous) starts a new file; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module image_header_field_parser import ihfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ihfp_byte_if.sink            data_chan,
  ihfp_result_if.source        result_chan
);

  `include "image_header_field_parser_assert.svh"

  // input register
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_sof;
  logic       s1_eof;
  logic       s1_adv;

  // parser state
  logic [5:0]  pos,   pos_next;
  logic [6:0]  cand,  cand_next;
  logic [31:0] wacc,  wacc_next;
  logic [31:0] hacc,  hacc_next;
  logic [15:0] dacc,  dacc_next;
  logic [7:0]  ctype, ctype_next;
  jpeg_state_t jst,   jst_next;
  logic        given, given_next;

  // state as seen by this byte (new file clears it first)
  logic [5:0]  e_pos;
  logic [6:0]  e_cand;
  logic [31:0] e_wacc;
  logic [31:0] e_hacc;
  logic [15:0] e_dacc;
  logic [7:0]  e_ctype;
  jpeg_state_t e_jst;
  logic        e_given;

  // result register
  logic    res_valid;
  result_t res;
  result_t r;
  logic    emit;

  sig_pick_t  pick;
  jpeg_step_t jw;

  logic [1:0] lane_w;
  logic [1:0] lane_h;

  assign s1_adv         = s1_valid && (!res_valid || result_chan.ready);
  assign data_chan.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_chan.ready) begin
      s1_valid <= data_chan.valid;
    end
    if (data_chan.valid && data_chan.ready) begin
      s1_data <= data_chan.data_byte;
      s1_sof  <= data_chan.start_of_file;
      s1_eof  <= data_chan.end_of_file;
    end
  end

  always_comb begin
    if (s1_sof) begin
      e_pos   = '0;
      e_cand  = '1;
      e_wacc  = '0;
      e_hacc  = '0;
      e_dacc  = '0;
      e_ctype = '0;
      e_jst   = '{phase: PH_PREFIX, seg_left: '0, seg_hi: '0};
      e_given = 1'b0;
    end else begin
      e_pos   = pos;
      e_cand  = cand;
      e_wacc  = wacc;
      e_hacc  = hacc;
      e_dacc  = dacc;
      e_ctype = ctype;
      e_jst   = jst;
      e_given = given;
    end
  end

  ihfp_sig u_sig (
    .pos  (e_pos),
    .cand (e_cand),
    .data (s1_data),
    .pick (pick)
  );

  ihfp_jpeg u_jpeg (
    .cur    (e_jst),
    .data   (s1_data),
    .width  (e_wacc[15:0]),
    .height (e_hacc[15:0]),
    .depth  (e_dacc[7:0]),
    .step   (jw)
  );

  assign lane_w = 2'(e_pos - 6'd18);
  assign lane_h = 2'(e_pos - 6'd22);

  always_comb begin
    pos_next   = e_pos;
    cand_next  = e_cand;
    wacc_next  = e_wacc;
    hacc_next  = e_hacc;
    dacc_next  = e_dacc;
    ctype_next = e_ctype;
    jst_next   = e_jst;
    given_next = e_given;
    emit       = 1'b0;
    r          = '0;
    if (!e_given) begin
      cand_next = pick.cand;
      if (pick.none) begin
        emit     = 1'b1;
        r.fmt    = FMT_UNKNOWN;
        r.status = ST_UNRECOGNIZED;
      end else begin
        case (pick.first)
          CAND_PNG: begin
            // big-endian IHDR fields
            if (e_pos >= 6'd16 && e_pos <= 6'd19) begin
              wacc_next = {e_wacc[23:0], s1_data};
            end else if (e_pos >= 6'd20 && e_pos <= 6'd23) begin
              hacc_next = {e_hacc[23:0], s1_data};
            end else if (e_pos == 6'd24) begin
              dacc_next = {8'd0, s1_data};
            end else if (e_pos == 6'd25) begin
              ctype_next    = s1_data;
              emit          = 1'b1;
              r.fmt         = FMT_PNG;
              r.status      = ST_OK;
              r.width       = e_wacc;
              r.height      = e_hacc;
              r.dims_valid  = 1'b1;
              r.bit_depth   = e_dacc[7:0];
              r.depth_valid = 1'b1;
              r.color_type  = s1_data;
            end
          end
          CAND_JPEG: begin
            if (e_pos == 6'd2) begin
              jst_next.phase = PH_CODE;
            end else if (e_pos >= 6'd3) begin
              jst_next = jw.st;
              if (jw.w_we) begin
                wacc_next = {16'd0, jw.width};
              end
              if (jw.h_we) begin
                hacc_next = {16'd0, jw.height};
              end
              if (jw.d_we) begin
                dacc_next = {8'd0, jw.depth};
              end
              if (jw.emit) begin
                emit  = 1'b1;
                r.fmt = FMT_JPEG;
                if (jw.frame_ok) begin
                  r.status      = ST_OK;
                  r.width       = {16'd0, jw.width};
                  r.height      = {16'd0, jw.height};
                  r.dims_valid  = 1'b1;
                  r.bit_depth   = jw.depth3;
                  r.depth_valid = 1'b1;
                end else begin
                  r.status = ST_NO_FRAME;
                end
              end
            end
          end
          CAND_GIF: begin
            // little-endian logical screen descriptor
            if (e_pos == 6'd6) begin
              wacc_next = e_wacc | {24'd0, s1_data};
            end else if (e_pos == 6'd7) begin
              wacc_next = e_wacc | {16'd0, s1_data, 8'd0};
            end else if (e_pos == 6'd8) begin
              hacc_next = e_hacc | {24'd0, s1_data};
            end else if (e_pos == 6'd9) begin
              hacc_next = e_hacc | {16'd0, s1_data, 8'd0};
            end else if (e_pos == 6'd10) begin
              emit          = 1'b1;
              r.fmt         = FMT_GIF;
              r.status      = ST_OK;
              r.width       = e_wacc;
              r.height      = e_hacc;
              r.dims_valid  = 1'b1;
              r.bit_depth   = {5'd0, s1_data[6:4]} + 8'd1;
              r.depth_valid = 1'b1;
            end
          end
          CAND_BMP: begin
            if (e_pos >= 6'd18 && e_pos <= 6'd21) begin
              wacc_next = e_wacc | ({24'd0, s1_data} << {lane_w, 3'b000});
            end else if (e_pos >= 6'd22 && e_pos <= 6'd25) begin
              hacc_next = e_hacc | ({24'd0, s1_data} << {lane_h, 3'b000});
            end else if (e_pos == 6'd28) begin
              dacc_next = e_dacc | {8'd0, s1_data};
            end else if (e_pos == 6'd29) begin
              dacc_next     = e_dacc | {s1_data, 8'd0};
              emit          = 1'b1;
              r.fmt         = FMT_BMP;
              r.status      = ST_OK;
              r.width       = e_wacc;
              r.height      = e_hacc;
              r.dims_valid  = 1'b1;
              r.bit_depth   = e_dacc[7:0];
              r.depth_valid = 1'b1;
            end
          end
          CAND_TII, CAND_TMM: begin
            if (e_pos == 6'd3) begin
              emit     = 1'b1;
              r.fmt    = FMT_TIFF;
              r.status = ST_OK;
            end
          end
          default: begin
            if (e_pos == 6'd11) begin
              emit          = 1'b1;
              r.fmt         = FMT_WEBP;
              r.status      = ST_OK;
              r.bit_depth   = WEBP_DEPTH;
              r.depth_valid = 1'b1;
            end
          end
        endcase
        // truncated: report the format only if its signature was complete
        if (!emit && s1_eof) begin
          emit     = 1'b1;
          r.status = ST_TRUNCATED;
          if (({1'b0, e_pos} + 7'd1) >= {3'd0, sig_len(pick.first)}) begin
            r.fmt = cand_format(pick.first);
          end else begin
            r.fmt = FMT_UNKNOWN;
          end
        end
      end
      given_next = emit;
      pos_next   = (e_pos != POS_MAX) ? e_pos + 6'd1 : e_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      cand  <= '1;
      wacc  <= '0;
      hacc  <= '0;
      dacc  <= '0;
      ctype <= '0;
      jst   <= '{phase: PH_PREFIX, seg_left: '0, seg_hi: '0};
      given <= 1'b0;
    end else if (s1_adv) begin
      pos   <= pos_next;
      cand  <= cand_next;
      wacc  <= wacc_next;
      hacc  <= hacc_next;
      dacc  <= dacc_next;
      ctype <= ctype_next;
      jst   <= jst_next;
      given <= given_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= emit;
    end else if (result_chan.ready) begin
      res_valid <= 1'b0;
    end
    if (s1_adv && emit) begin
      res <= r;
    end
  end

  assign result_chan.valid          = res_valid;
  assign result_chan.format         = res.fmt;
  assign result_chan.status         = res.status;
  assign result_chan.image_width    = res.width;
  assign result_chan.image_height   = res.height;
  assign result_chan.dims_valid     = res.dims_valid;
  assign result_chan.bit_depth      = res.bit_depth;
  assign result_chan.depth_valid    = res.depth_valid;
  assign result_chan.png_color_type = res.color_type;

  `IHFP_ASSERT_SAME(a_dims_only_ok, res_valid && res.dims_valid, res.status == ST_OK,
    "dimensions flagged valid on a failed result")
  `IHFP_ASSERT_SAME(a_unknown_no_fields, res_valid && res.fmt == FMT_UNKNOWN,
    !res.depth_valid && !res.dims_valid, "unknown format carries header fields")
  `IHFP_ASSERT_NEXT(a_result_marks_file, s1_adv && emit, given,
    "file not marked done after its result")
  `IHFP_ASSERT_NEXT(a_done_file_frozen, s1_adv && given && !s1_sof, $stable(pos) && !res_valid,
    "parser advanced on a byte after the file's result")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams PNG, JPEG, GIF, BMP, TIFF and WEBP headers, broken signatures and
// noise into the header parser, one byte per transaction. A byte-level
// predictor of the parser runs on every accepted byte, and each header summary
// that comes out is compared field by field with the oldest predicted summary.
// ----------------------------------------------------------------------------

module testbench import ihfp_pkg::*; ();

  localparam int          RANDOM_BYTES = 1500;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          HOLD_CYCLES  = 500;
  localparam logic [7:0]  GIF_RES_MASK = 8'h70;

  typedef struct packed {
    logic [7:0] b;
    logic       sof;
    logic       eof;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst;

  ihfp_byte_if   byte_chan ();
  ihfp_result_if result_chan ();

  image_header_field_parser uut (
    .clk         (clk),
    .rst         (rst),
    .data_chan   (byte_chan),
    .result_chan (result_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  file_byte_t file_bytes_q[$];
  result_t    predicted_headers[$];
  logic [7:0] fbuf[$];
  int         bytes_queued = 0;
  int         bytes_taken  = 0;
  int         errors       = 0;

  // --------------------------------------------------------------------------
  // Header predictor state
  // --------------------------------------------------------------------------
  logic [5:0]  f_pos;
  logic [6:0]  f_cand;
  logic [31:0] f_w;
  logic [31:0] f_h;
  logic [15:0] f_d;
  phase_t      f_ph;
  logic [15:0] f_seg;
  logic [7:0]  f_seghi;
  logic        f_done;

  task automatic clear_parse();
    f_pos   = '0;
    f_cand  = '1;
    f_w     = '0;
    f_h     = '0;
    f_d     = '0;
    f_ph    = PH_PREFIX;
    f_seg   = '0;
    f_seghi = '0;
    f_done  = 1'b0;
  endtask

  task automatic post_hdr(input logic [2:0] fm, input logic [1:0] st,
                          input logic [31:0] w, input logic [31:0] h, input logic dv,
                          input logic [7:0] d, input logic dpv, input logic [7:0] ct);
    result_t r;
    r.fmt         = fm;
    r.status      = st;
    r.width       = w;
    r.height      = h;
    r.dims_valid  = dv;
    r.bit_depth   = d;
    r.depth_valid = dpv;
    r.color_type  = ct;
    predicted_headers.push_back(r);
    f_done = 1'b1;
  endtask

  function automatic bit sig_hit(input logic [2:0] k, input logic [5:0] p,
                                 input logic [7:0] b);
    case (k)
      CAND_PNG:  return p >= 8 || b == SIG_PNG[p[2:0]];
      CAND_JPEG: return p >= 3 || b == SIG_JPG[p[1:0]];
      CAND_GIF: begin
        if (p >= 6) return 1'b1;
        if (p == 4) return b == GIF_VER_7 || b == GIF_VER_9;
        return b == SIG_GIF[p[2:0]];
      end
      CAND_BMP:  return p >= 2 || b == SIG_BMP[p[0]];
      CAND_TII:  return p >= 4 || b == SIG_TII[p[1:0]];
      CAND_TMM:  return p >= 4 || b == SIG_TMM[p[1:0]];
      default: begin
        if (p < 4) return b == SIG_RIFF[p[1:0]];
        if (p < 8) return 1'b1;
        if (p < 12) return b == SIG_WEBP[p[1:0]];
        return 1'b1;
      end
    endcase
  endfunction

  // JPEG marker walk, from the first marker code on
  task automatic walk_marker(input logic [7:0] b);
    logic [15:0] seglen;
    logic [7:0]  d3;
    case (f_ph)
      PH_PREFIX: begin
        if (b != MARKER_PFX) post_hdr(FMT_JPEG, ST_NO_FRAME, 0, 0, 0, 0, 0, 0);
        else f_ph = PH_CODE;
      end
      PH_CODE: begin
        if (b >= SOF_FIRST && b <= SOF_LAST) begin
          f_ph  = PH_SOF;
          f_seg = '0;
        end else begin
          f_ph = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        f_seghi = b;
        f_ph    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seglen = {f_seghi, b};
        if (seglen <= 16'd2) begin
          f_seg = '0;
          f_ph  = PH_PREFIX;
        end else begin
          f_seg = seglen - 16'd2;
          f_ph  = PH_SKIP;
        end
      end
      PH_SOF: begin
        // frame header: length(2) precision(1) height(2) width(2)
        if (f_seg == 16'd2) f_d = {8'h00, b};
        else if (f_seg == 16'd3 || f_seg == 16'd4) f_h = ((f_h << 8) | b) & 32'hFFFF;
        else if (f_seg >= 16'd5) f_w = ((f_w << 8) | b) & 32'hFFFF;
        if (f_seg >= 16'd6) begin
          d3 = f_d[7:0] * 8'd3;
          post_hdr(FMT_JPEG, ST_OK, f_w, f_h, 1'b1, d3, 1'b1, 8'h00);
        end else begin
          f_seg = f_seg + 16'd1;
        end
      end
      default: begin
        if (f_seg <= 16'd1) begin
          f_seg = '0;
          f_ph  = PH_PREFIX;
        end else begin
          f_seg = f_seg - 16'd1;
        end
      end
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic sof, input logic eof);
    logic [5:0] p;
    logic [2:0] k;
    logic [2:0] cur_fmt;
    int         sig_bytes;
    int         ci;
    if (sof) clear_parse();
    if (f_done) return;
    p = f_pos;
    for (ci = 0; ci < NUM_CAND; ci++)
      if (f_cand[ci] && !sig_hit(3'(ci), p, b)) f_cand[ci] = 1'b0;
    if (f_cand == '0) begin
      post_hdr(FMT_UNKNOWN, ST_UNRECOGNIZED, 0, 0, 0, 0, 0, 0);
    end else begin
      k = CAND_PNG;
      while (k < CAND_WEBP && !f_cand[k]) k++;
      case (k)
        CAND_PNG: begin
          cur_fmt   = FMT_PNG;
          sig_bytes = 8;
          if (p >= 16 && p <= 19) f_w = {f_w[23:0], b};
          else if (p >= 20 && p <= 23) f_h = {f_h[23:0], b};
          else if (p == 24) f_d = {8'h00, b};
          else if (p == 25) post_hdr(FMT_PNG, ST_OK, f_w, f_h, 1'b1, f_d[7:0], 1'b1, b);
        end
        CAND_JPEG: begin
          cur_fmt   = FMT_JPEG;
          sig_bytes = 3;
          if (p == 2) f_ph = PH_CODE;
          else if (p >= 3) walk_marker(b);
        end
        CAND_GIF: begin
          cur_fmt   = FMT_GIF;
          sig_bytes = 6;
          if (p == 6 || p == 7) f_w = f_w | (32'(b) << (8 * (p - 6)));
          else if (p == 8 || p == 9) f_h = f_h | (32'(b) << (8 * (p - 8)));
          else if (p == 10)
            post_hdr(FMT_GIF, ST_OK, f_w, f_h, 1'b1, ((b & GIF_RES_MASK) >> 4) + 8'd1,
                     1'b1, 8'h00);
        end
        CAND_BMP: begin
          cur_fmt   = FMT_BMP;
          sig_bytes = 2;
          if (p >= 18 && p <= 21) f_w = f_w | (32'(b) << (8 * (p - 18)));
          else if (p >= 22 && p <= 25) f_h = f_h | (32'(b) << (8 * (p - 22)));
          else if (p == 28 || p == 29) begin
            f_d = f_d | (16'(b) << (8 * (p - 28)));
            if (p == 29) post_hdr(FMT_BMP, ST_OK, f_w, f_h, 1'b1, f_d[7:0], 1'b1, 8'h00);
          end
        end
        CAND_TII, CAND_TMM: begin
          cur_fmt   = FMT_TIFF;
          sig_bytes = 4;
          if (p == 3) post_hdr(FMT_TIFF, ST_OK, 0, 0, 0, 0, 0, 0);
        end
        default: begin
          cur_fmt   = FMT_WEBP;
          sig_bytes = 12;
          if (p == 11) post_hdr(FMT_WEBP, ST_OK, 0, 0, 0, WEBP_DEPTH, 1'b1, 8'h00);
        end
      endcase
      // truncated: format only counts if the whole signature was seen
      if (!f_done && eof)
        post_hdr((int'(p) + 1 >= sig_bytes) ? cur_fmt : FMT_UNKNOWN, ST_TRUNCATED,
                 0, 0, 0, 0, 0, 0);
    end
    if (f_pos < POS_MAX) f_pos = f_pos + 6'd1;
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: bursts with random gaps
  // --------------------------------------------------------------------------
  file_byte_t nxt;
  int         burst_left = 0;
  int         gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_chan.valid         <= 1'b0;
      byte_chan.data_byte     <= 8'h00;
      byte_chan.start_of_file <= 1'b0;
      byte_chan.end_of_file   <= 1'b0;
      clear_parse();
    end else begin
      if (byte_chan.valid && byte_chan.ready) begin
        parse_byte(byte_chan.data_byte, byte_chan.start_of_file, byte_chan.end_of_file);
        bytes_taken++;
      end
      if (!byte_chan.valid || byte_chan.ready) begin
        if (gap_left > 0 || file_bytes_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          byte_chan.valid <= 1'b0;
        end else begin
          nxt = file_bytes_q.pop_front();
          byte_chan.valid         <= 1'b1;
          byte_chan.data_byte     <= nxt.b;
          byte_chan.start_of_file <= nxt.sof;
          byte_chan.end_of_file   <= nxt.eof;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: stall modes of its own, plus long hold-offs
  // --------------------------------------------------------------------------
  int hold_count = 0;
  int hold_left  = 0;
  int rx_mode    = 0;
  int mode_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_chan.ready <= 1'b0;
    end else begin
      // one hold-off in each half of the random traffic
      if ((hold_count == 0 && bytes_taken >= 400) ||
          (hold_count == 1 && bytes_taken >= 1300)) begin
        hold_left = HOLD_CYCLES;
        hold_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_chan.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: result_chan.ready <= 1'b1;
          1: result_chan.ready <= ($urandom_range(0, 1) == 1);
          2: result_chan.ready <= ($urandom_range(0, 7) != 0);
          default: result_chan.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  result_t want;

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_chan.valid && result_chan.ready) begin
      if (predicted_headers.size() == 0) begin
        if (errors < 40)
          $error("unexpected result transaction: format %0d status %0d",
                 result_chan.format, result_chan.status);
        errors++;
      end else begin
        want = predicted_headers.pop_front();
        cmp_field("format",         want.fmt,         result_chan.format);
        cmp_field("status",         want.status,      result_chan.status);
        cmp_field("image_width",    want.width,       result_chan.image_width);
        cmp_field("image_height",   want.height,      result_chan.image_height);
        cmp_field("dims_valid",     want.dims_valid,  result_chan.dims_valid);
        cmp_field("bit_depth",      want.bit_depth,   result_chan.bit_depth);
        cmp_field("depth_valid",    want.depth_valid, result_chan.depth_valid);
        cmp_field("png_color_type", want.color_type,  result_chan.png_color_type);
      end
    end
  end

  int cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // File builders
  // --------------------------------------------------------------------------
  task automatic add_b(input logic [7:0] b);
    fbuf.push_back(b);
  endtask

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_b(s[i]);
  endtask

  task automatic add_be(input logic [31:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) add_b(v[8*i +: 8]);
  endtask

  task automatic add_le(input logic [31:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) add_b(v[8*i +: 8]);
  endtask

  // bytes past end of file carry random end flags and must be ignored
  task automatic ship(input bit with_sof, input int eof_at);
    file_byte_t it;
    int         i;
    for (i = 0; i < fbuf.size(); i++) begin
      it.b   = fbuf[i];
      it.sof = with_sof && i == 0;
      it.eof = (i == eof_at) || (eof_at >= 0 && i > eof_at && $urandom_range(0, 1) == 1);
      file_bytes_q.push_back(it);
      bytes_queued++;
    end
    fbuf.delete();
  endtask

  task automatic png_head();
    add_be(32'h89504E47, 4);
    add_be(32'h0D0A1A0A, 4);
    add_be($urandom_range(0, 3) == 0 ? $urandom : 32'h0000000D, 4);
    if ($urandom_range(0, 3) == 0) add_be($urandom, 4);
    else add_str("IHDR");
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      4: return $urandom_range(1, 4096);
      default: return $urandom;
    endcase
  endfunction

  task automatic gen_jpeg();
    int         nseg;
    int         s;
    int         len;
    int         j;
    logic [7:0] code;
    add_be(24'hFFD8FF, 3);
    nseg = $urandom_range(0, 3);
    for (s = 0; s < nseg; s++) begin
      if (s > 0) add_b(MARKER_PFX);
      code = 8'($urandom);
      // fill and standalone codes are still walked as if they had a length
      if ((code >= SOF_FIRST && code <= SOF_LAST) || $urandom_range(0, 3) == 0)
        code = MARKER_PFX;
      add_b(code);
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(256, 420) : $urandom_range(0, 20);
      add_be(len, 2);
      for (j = 2; j < len; j++) add_b(8'($urandom));
    end
    if (nseg > 0 && $urandom_range(0, 4) == 0) begin
      add_b(8'($urandom_range(0, 254)));
    end else begin
      if (nseg > 0) add_b(MARKER_PFX);
      add_b(SOF_FIRST + 8'($urandom_range(0, 3)));
      add_be($urandom, 2);
      add_b(8'($urandom));
      add_be($urandom, 2);
      add_be($urandom, 2);
    end
  endtask

  task automatic gen_file(input int kind);
    int n;
    case (kind)
      0: begin
        png_head();
        add_be(pick32(), 4);
        add_be(pick32(), 4);
        add_b($urandom_range(0, 1) == 1 ? 8'($urandom) : 8'(1 << $urandom_range(0, 4)));
        add_b(8'($urandom));
      end
      1, 2: gen_jpeg();
      3: begin
        add_str("GIF8");
        add_b($urandom_range(0, 1) == 1 ? GIF_VER_7 : GIF_VER_9);
        add_str("a");
        add_le($urandom, 2);
        add_le($urandom, 2);
        add_b(8'($urandom));
      end
      4: begin
        add_str("BM");
        repeat (16) add_b(8'($urandom));
        add_le(pick32(), 4);
        add_le(pick32(), 4);
        add_le($urandom, 2);
        add_le($urandom_range(0, 1) == 1 ? 32'($urandom_range(0, 65535)) : 32'd24, 2);
      end
      5: begin
        if ($urandom_range(0, 1) == 1) add_be(32'h49492A00, 4);
        else add_be(32'h4D4D002A, 4);
      end
      6: begin
        add_str("RIFF");
        add_le($urandom, 4);
        add_str("WEBP");
      end
      default: begin
        n = $urandom_range(1, 8);
        repeat (n) add_b(8'($urandom));
      end
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_b(8'($urandom));
  endtask

  task automatic run_directed();
    // first file after reset, no start flag: GIF89a, depth from 0x70
    add_str("GIF89a");
    add_le(16'hFF00, 2);
    add_le(16'hFFFF, 2);
    add_b(8'h70);
    ship(1'b0, 10);
    // PNG, all-ones width, sign-bit height
    add_be(32'h89504E47, 4);
    add_be(32'h0D0A1A0A, 4);
    add_be(32'h0000000D, 4);
    add_str("IHDR");
    add_be(32'hFFFFFFFF, 4);
    add_be(32'h80000000, 4);
    add_b(8'h10);
    add_b(8'h06);
    ship(1'b1, -1);
    // PNG, zero width, trailing bytes after the result
    add_be(32'h89504E47, 4);
    add_be(32'h0D0A1A0A, 4);
    add_be(32'h0000000D, 4);
    add_str("IHDR");
    add_be(32'h0, 4);
    add_be(32'h1, 4);
    add_be(32'hFFFF00FF, 4);
    ship(1'b1, 27);
    // BMP, top-down rows, 0x118 bpp truncated
    add_str("BM");
    repeat (16) add_b(8'h00);
    add_le(32'd640, 4);
    add_le(32'hFFFFFE20, 4);
    add_le(32'h0, 2);
    add_le(32'h0118, 2);
    ship(1'b1, 29);
    // JPEG: APP0 skip, length below 2, fill marker, then SOF2
    add_be(32'hFFD8FFE0, 4);
    add_be(32'h0010, 2);
    repeat (14) add_b(8'hFF);
    add_be(32'hFFFE0001, 4);
    add_be(32'hFFFF0002, 4);
    add_be(32'hFFC20011, 4);
    add_be(32'h0801E002, 4);
    add_b(8'h80);
    ship(1'b1, -1);
    // JPEG, bad prefix after a segment
    add_be(32'hFFD8FFE1, 4);
    add_be(32'h0003AA, 3);
    add_b(8'h00);
    ship(1'b1, -1);
    add_be(32'h49492A00, 4);
    ship(1'b1, 3);
    add_be(32'h4D4D002A, 4);
    ship(1'b1, -1);
    add_str("RIFF");
    add_be(32'h11223344, 4);
    add_str("WEBP");
    ship(1'b1, -1);
    add_b(8'h00);
    ship(1'b1, -1);
    // truncated inside and right after a signature
    add_be(32'h89504E47, 4);
    add_be(32'h0D0A, 2);
    ship(1'b1, 5);
    add_str("GIF87a");
    add_be(32'h2000, 2);
    ship(1'b1, 7);
    add_be(32'hFFD8FF, 3);
    ship(1'b1, 2);
    // end of file on byte 0, then bytes that must be ignored
    add_str("BMP");
    ship(1'b1, 0);
    add_str("BX");
    ship(1'b1, -1);
    // SOF0 with largest precision and dimensions
    add_be(32'hFFD8FFC0, 4);
    add_be(32'h0011, 2);
    add_b(8'hFF);
    add_be(32'hFFFFFFFF, 4);
    ship(1'b1, -1);
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || predicted_headers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  rand_bytes;
    int  kind;
    int  n;
    int  eof_at;
    int  pos;
    bit  paused;
    rand_bytes = 0;
    paused     = 1'b0;
    rst                       = 1'b1;
    byte_chan.valid           = 1'b0;
    byte_chan.data_byte       = 8'h00;
    byte_chan.start_of_file   = 1'b0;
    byte_chan.end_of_file     = 1'b0;
    result_chan.ready         = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    wait_idle();

    while (rand_bytes < RANDOM_BYTES) begin
      kind = $urandom_range(0, 8);
      if (kind == 7) begin
        // near miss: a good header with one early byte replaced
        gen_file($urandom_range(0, 6));
        pos = $urandom_range(0, (fbuf.size() > 12) ? 11 : fbuf.size() - 1);
        fbuf[pos] = 8'($urandom);
      end else begin
        gen_file(kind);
      end
      n = fbuf.size();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: eof_at = n - 1;
        6, 7:             eof_at = $urandom_range(0, n - 1);
        8:                eof_at = -1;
        default: begin
          eof_at = n - 1;
          repeat ($urandom_range(1, 4)) add_b(8'($urandom));
        end
      endcase
      rand_bytes += fbuf.size();
      ship($urandom_range(0, 29) != 0, eof_at);
      if (!paused && rand_bytes >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        wait_idle();
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
